// ----- rtl/hctb_pkg.sv -----
// Package for the Huffman code table builder: fixed field widths and the
// sequencer state type. No dependencies.
package hctb_pkg;

    localparam int LEAF_WEIGHT_W = 24;
    localparam int SYMBOL_W      = 8;
    localparam int LEAF_NUM_W    = 4;
    localparam int CODE_LEN_W    = 4;
    localparam int CODE_WORD_W   = 15;
    localparam int WPL_W         = 32;

    typedef enum logic [7:0] {
        S_LOAD      = 8'b0000_0001,
        S_SCAN      = 8'b0000_0010,
        S_SCAN_END  = 8'b0000_0100,
        S_MERGE_A   = 8'b0000_1000,
        S_MERGE_B   = 8'b0001_0000,
        S_WALK_RD   = 8'b0010_0000,
        S_WALK_STEP = 8'b0100_0000,
        S_EMIT      = 8'b1000_0000
    } t_state;

endpackage

// ----- rtl/hctb_stream_if.sv -----
// Valid/ready stream interfaces for leaf requests and code results.
// Depends on hctb_pkg.
interface hctb_leaf_if import hctb_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [LEAF_WEIGHT_W-1:0] leaf_weight;
    logic [SYMBOL_W-1:0]      leaf_symbol;

    modport source (output valid, output leaf_weight, output leaf_symbol, input ready);
    modport sink   (input valid, input leaf_weight, input leaf_symbol, output ready);
endinterface

interface hctb_code_if import hctb_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [LEAF_NUM_W-1:0]  leaf_number;
    logic [SYMBOL_W-1:0]    symbol_out;
    logic [CODE_LEN_W-1:0]  code_length;
    logic [CODE_WORD_W-1:0] code_word;
    logic [WPL_W-1:0]       weighted_length;
    logic                   last_code;

    modport source (output valid, output leaf_number, output symbol_out, output code_length,
                    output code_word, output weighted_length, output last_code, input ready);
    modport sink   (input valid, input leaf_number, input symbol_out, input code_length,
                    input code_word, input weighted_length, input last_code, output ready);
endinterface

// ----- rtl/hctb_node_mem.sv -----
// Node table storage: node weights, parent/side links and leaf symbols.
// One write and one registered read port per memory. Depends on hctb_pkg.
module hctb_node_mem import hctb_pkg::*; #(
    parameter int NN = 31,
    parameter int NL = 16,
    parameter int NW = 28,
    parameter int IW = 5,
    parameter int LW = 4
) (
    input  logic                i_clk,
    input  logic                i_w_we,
    input  logic [IW-1:0]       i_w_waddr,
    input  logic [NW-1:0]       i_w_wdata,
    input  logic [IW-1:0]       i_w_raddr,
    output logic [NW-1:0]       o_w_rdata,
    input  logic                i_p_we,
    input  logic [IW-1:0]       i_p_waddr,
    input  logic [IW:0]         i_p_wdata,
    input  logic [IW-1:0]       i_p_raddr,
    output logic [IW:0]         o_p_rdata,
    input  logic                i_s_we,
    input  logic [LW-1:0]       i_s_waddr,
    input  logic [SYMBOL_W-1:0] i_s_wdata,
    input  logic [LW-1:0]       i_s_raddr,
    output logic [SYMBOL_W-1:0] o_s_rdata
);

    logic [NW-1:0]       r_weight_mem [NN];
    logic [IW:0]         r_link_mem   [NN];
    logic [SYMBOL_W-1:0] r_sym_mem    [NL];

    always_ff @(posedge i_clk) begin
        if (i_w_we) begin
            r_weight_mem[i_w_waddr] <= i_w_wdata;
        end
        o_w_rdata <= r_weight_mem[i_w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_p_we) begin
            r_link_mem[i_p_waddr] <= i_p_wdata;
        end
        o_p_rdata <= r_link_mem[i_p_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_s_we) begin
            r_sym_mem[i_s_waddr] <= i_s_wdata;
        end
        o_s_rdata <= r_sym_mem[i_s_raddr];
    end

endmodule

// ----- rtl/hctb_min2.sv -----
// Two-minimum tracker: fed one node per cycle, keeps the lightest and the
// second lightest, ties to the earlier (lower) index. Depends on hctb_pkg.
module hctb_min2 import hctb_pkg::*; #(
    parameter int NW = 28,
    parameter int IW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_vld,
    input  logic [IW-1:0] i_idx,
    input  logic [NW-1:0] i_w,
    output logic [IW-1:0] o_a_idx,
    output logic [NW-1:0] o_a_w,
    output logic [IW-1:0] o_b_idx,
    output logic [NW-1:0] o_b_w
);

    logic          r_a_found, r_b_found;
    logic [IW-1:0] r_a_idx, r_b_idx;
    logic [NW-1:0] r_a_w, r_b_w;
    logic          lt_a, lt_b;

    assign lt_a = !r_a_found || (i_w < r_a_w);
    assign lt_b = !r_b_found || (i_w < r_b_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_a_found <= 1'b0;
            r_b_found <= 1'b0;
        end else if (i_vld) begin
            if (lt_a) begin
                r_a_found <= 1'b1;
                r_b_found <= r_a_found;
            end else if (lt_b) begin
                r_b_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            if (lt_a) begin
                r_a_idx <= i_idx;
                r_a_w   <= i_w;
                r_b_idx <= r_a_idx;
                r_b_w   <= r_a_w;
            end else if (lt_b) begin
                r_b_idx <= i_idx;
                r_b_w   <= i_w;
            end
        end
    end

    assign o_a_idx = r_a_idx;
    assign o_a_w   = r_a_w;
    assign o_b_idx = r_b_idx;
    assign o_b_w   = r_b_w;

endmodule

// ----- rtl/huffman_code_table_builder_core.sv -----
// Huffman code table builder, top level: sequencer, shared adder and output
// register. Depends on hctb_pkg, hctb_stream_if, hctb_node_mem, hctb_min2.
//
// Usage: i_leaf carries NUM_LEAVES leaf requests (weight, symbol), one per
// cycle while ready is high. After the last leaf of a table ready drops and
// the tree is built: each new node k (NUM_LEAVES .. 2*NUM_LEAVES-2) scans the
// k existing nodes through one compare unit, one node per cycle, then links
// the two chosen children in S_MERGE_A and S_MERGE_B. Codes are then found
// by walking each leaf up to the root, through S_WALK_RD and S_WALK_STEP for
// each tree level and then S_EMIT, and the results leave on o_code in leaf
// order; the last one carries last_code and the weighted path length.
// A stalled receiver holds the output register and pauses the walk; the next
// table is accepted while the final result still waits.
// Reset (synchronous, active low) empties the table and the output register.
module huffman_code_table_builder_core import hctb_pkg::*; #(
    parameter int NUM_LEAVES  = 16,
    parameter int WEIGHT_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hctb_leaf_if.sink  i_leaf,
    hctb_code_if.source o_code
);

    localparam int NN = 2 * NUM_LEAVES - 1;
    localparam int IW = $clog2(NN);
    localparam int LW = $clog2(NUM_LEAVES);
    localparam int NW = WEIGHT_BITS + LW;
    localparam int AW = ((NW > WPL_W) ? NW : WPL_W) + 1;

    t_state                 r_state, n_state;
    logic [LW-1:0]          r_leaf, n_leaf;
    logic [IW-1:0]          r_k, n_k;
    logic [IW-1:0]          r_scan, n_scan;
    logic                   r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]          r_cmp_idx, n_cmp_idx;
    logic [NN-1:0]          r_has_par, n_has_par;
    logic [IW-1:0]          r_cur, n_cur;
    logic [LW-1:0]          r_len, n_len;
    logic [CODE_WORD_W-1:0] r_code, n_code;
    logic [WPL_W-1:0]       r_wpl, n_wpl;

    logic                   r_out_vld, n_out_vld;
    logic [LEAF_NUM_W-1:0]  r_out_num, n_out_num;
    logic [SYMBOL_W-1:0]    r_out_sym, n_out_sym;
    logic [CODE_LEN_W-1:0]  r_out_len, n_out_len;
    logic [CODE_WORD_W-1:0] r_out_code, n_out_code;
    logic [WPL_W-1:0]       r_out_wpl, n_out_wpl;
    logic                   r_out_last, n_out_last;

    logic [WEIGHT_BITS+LEAF_WEIGHT_W-1:0] win_pad;
    logic [NW-1:0]          leaf_w;
    logic [IW-1:0]          leaf_node;
    logic [LW+3:0]          leaf_pad, len_pad;
    logic                   accept, last_leaf, out_free;

    logic                   w_we, p_we, s_we;
    logic [IW-1:0]          w_waddr, w_raddr, p_waddr;
    logic [NW-1:0]          w_wdata, w_rdata;
    logic [IW:0]            p_wdata, p_rdata;
    logic [SYMBOL_W-1:0]    s_rdata;

    logic [IW-1:0]          a_idx, b_idx;
    logic [NW-1:0]          a_w, b_w;
    logic                   min_clear, min_vld;

    logic [AW-1:0]          add_a, add_b, add_sum;
    logic [WPL_W-1:0]       wpl_sat;

    assign win_pad   = {{WEIGHT_BITS{1'b0}}, i_leaf.leaf_weight};
    assign leaf_w    = {{LW{1'b0}}, win_pad[WEIGHT_BITS-1:0]};
    assign leaf_node = IW'(r_leaf);
    assign leaf_pad  = {4'b0000, r_leaf};
    assign len_pad   = {4'b0000, r_len};
    assign last_leaf = (r_leaf == LW'(NUM_LEAVES - 1));
    assign accept    = i_leaf.valid && (r_state == S_LOAD);
    assign out_free  = !r_out_vld || o_code.ready;

    // shared adder: merge weight sums and path length accumulation
    assign add_a   = (r_state == S_MERGE_A) ? AW'(a_w) : AW'(r_wpl);
    assign add_b   = (r_state == S_MERGE_A) ? AW'(b_w) : AW'(w_rdata);
    assign add_sum = add_a + add_b;
    assign wpl_sat = (|add_sum[AW-1:WPL_W]) ? {WPL_W{1'b1}} : add_sum[WPL_W-1:0];

    assign w_we    = accept || (r_state == S_MERGE_A);
    assign w_waddr = accept ? leaf_node : r_k;
    assign w_wdata = accept ? leaf_w : add_sum[NW-1:0];
    assign w_raddr = ((r_state == S_SCAN) || (r_state == S_SCAN_END)) ? r_scan : leaf_node;
    assign p_we    = (r_state == S_MERGE_A) || (r_state == S_MERGE_B);
    assign p_waddr = (r_state == S_MERGE_A) ? a_idx : b_idx;
    assign p_wdata = {r_k, (r_state == S_MERGE_A)};
    assign s_we    = accept;

    assign min_clear = (r_state == S_LOAD) || (r_state == S_MERGE_B);
    assign min_vld   = r_cmp_vld && !r_has_par[r_cmp_idx];

    hctb_node_mem #(
        .NN(NN), .NL(NUM_LEAVES), .NW(NW), .IW(IW), .LW(LW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_w_we    (w_we),
        .i_w_waddr (w_waddr),
        .i_w_wdata (w_wdata),
        .i_w_raddr (w_raddr),
        .o_w_rdata (w_rdata),
        .i_p_we    (p_we),
        .i_p_waddr (p_waddr),
        .i_p_wdata (p_wdata),
        .i_p_raddr (r_cur),
        .o_p_rdata (p_rdata),
        .i_s_we    (s_we),
        .i_s_waddr (r_leaf),
        .i_s_wdata (i_leaf.leaf_symbol),
        .i_s_raddr (r_leaf),
        .o_s_rdata (s_rdata)
    );

    hctb_min2 #(.NW(NW), .IW(IW)) u_min2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (min_clear),
        .i_vld   (min_vld),
        .i_idx   (r_cmp_idx),
        .i_w     (w_rdata),
        .o_a_idx (a_idx),
        .o_a_w   (a_w),
        .o_b_idx (b_idx),
        .o_b_w   (b_w)
    );

    always_comb begin
        n_state    = r_state;
        n_leaf     = r_leaf;
        n_k        = r_k;
        n_scan     = r_scan;
        n_cmp_vld  = (r_state == S_SCAN);
        n_cmp_idx  = r_scan;
        n_has_par  = r_has_par;
        n_cur      = r_cur;
        n_len      = r_len;
        n_code     = r_code;
        n_wpl      = r_wpl;
        n_out_vld  = r_out_vld && !o_code.ready;
        n_out_num  = r_out_num;
        n_out_sym  = r_out_sym;
        n_out_len  = r_out_len;
        n_out_code = r_out_code;
        n_out_wpl  = r_out_wpl;
        n_out_last = r_out_last;
        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (last_leaf) begin
                        n_k     = IW'(NUM_LEAVES);
                        n_scan  = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_leaf = r_leaf + LW'(1);
                    end
                end
            end
            S_SCAN: begin
                if (r_scan == r_k - IW'(1)) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_scan = r_scan + IW'(1);
                end
            end
            S_SCAN_END: begin
                n_state = S_MERGE_A;
            end
            S_MERGE_A: begin
                n_has_par[a_idx] = 1'b1;
                n_state          = S_MERGE_B;
            end
            S_MERGE_B: begin
                n_has_par[b_idx] = 1'b1;
                if (r_k == IW'(NN - 1)) begin
                    n_leaf  = '0;
                    n_cur   = '0;
                    n_len   = '0;
                    n_code  = '0;
                    n_wpl   = '0;
                    n_state = S_WALK_RD;
                end else begin
                    n_k     = r_k + IW'(1);
                    n_scan  = '0;
                    n_state = S_SCAN;
                end
            end
            S_WALK_RD: begin
                n_state = S_WALK_STEP;
            end
            S_WALK_STEP: begin
                if (r_has_par[r_cur]) begin
                    if (!p_rdata[0] && (len_pad < (LW + 4)'(CODE_WORD_W))) begin
                        n_code = r_code | (CODE_WORD_W'(1) << r_len);
                    end
                    n_len   = r_len + LW'(1);
                    n_wpl   = wpl_sat;
                    n_cur   = p_rdata[IW:1];
                    n_state = S_WALK_RD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_num  = leaf_pad[LEAF_NUM_W-1:0];
                    n_out_sym  = s_rdata;
                    n_out_len  = len_pad[CODE_LEN_W-1:0];
                    n_out_code = r_code;
                    n_out_wpl  = last_leaf ? r_wpl : '0;
                    n_out_last = last_leaf;
                    n_len      = '0;
                    n_code     = '0;
                    if (last_leaf) begin
                        n_leaf    = '0;
                        n_has_par = '0;
                        n_state   = S_LOAD;
                    end else begin
                        n_leaf  = r_leaf + LW'(1);
                        n_cur   = IW'(r_leaf + LW'(1));
                        n_state = S_WALK_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_leaf    <= '0;
            r_k       <= '0;
            r_scan    <= '0;
            r_cmp_vld <= 1'b0;
            r_has_par <= '0;
            r_cur     <= '0;
            r_len     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_leaf    <= n_leaf;
            r_k       <= n_k;
            r_scan    <= n_scan;
            r_cmp_vld <= n_cmp_vld;
            r_has_par <= n_has_par;
            r_cur     <= n_cur;
            r_len     <= n_len;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= n_cmp_idx;
        r_code     <= n_code;
        r_wpl      <= n_wpl;
        r_out_num  <= n_out_num;
        r_out_sym  <= n_out_sym;
        r_out_len  <= n_out_len;
        r_out_code <= n_out_code;
        r_out_wpl  <= n_out_wpl;
        r_out_last <= n_out_last;
    end

    assign i_leaf.ready           = (r_state == S_LOAD);
    assign o_code.valid           = r_out_vld;
    assign o_code.leaf_number     = r_out_num;
    assign o_code.symbol_out      = r_out_sym;
    assign o_code.code_length     = r_out_len;
    assign o_code.code_word       = r_out_code;
    assign o_code.weighted_length = r_out_wpl;
    assign o_code.last_code       = r_out_last;

endmodule
